[design/lcar_pkg.sv]
// Shared constants, types and helper functions of the load cell ADC reader.
package lcar_pkg;

  localparam int DATA_BITS  = 24;
  localparam int TARE_READS = 5;

  localparam int RAW_W      = 24;
  localparam int WEIGHT_W   = 32;
  localparam int SCALE_W    = 32;
  localparam int CNT_W      = 24;
  localparam int SUM_W      = 27;
  localparam int BIT_CNT_W  = $clog2(DATA_BITS + 1);
  localparam int READS_W    = $clog2(TARE_READS + 1);
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Tare average by multiplication with a rounded-up reciprocal.
  localparam int DIV_SHIFT   = 30;
  localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + TARE_READS - 1) / TARE_READS;
  localparam int DIV_RECIP_W = $clog2(DIV_RECIP + 1);
  localparam int DIV_PROD_W  = SUM_W + DIV_RECIP_W;

  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = RAW_W + 2 + SCALE_W;

  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TARE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CLKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARE_GAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_DOWN   = 3'd4;

  typedef struct packed {
    logic [1:0]         gain_clks;
    logic [CNT_W-1:0]   timeout_ticks;
    logic [CNT_W-1:0]   tare_gap_ticks;
    logic [SCALE_W-1:0] scale_recip;
    logic               power_down;
  } lcar_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    sck;
    logic                    busy;
    logic                    done;
    logic                    tout;
    logic                    tared;
    logic                    tare_done;
    logic signed [RAW_W-1:0] raw;
    logic signed [SUM_W-1:0] sum;
  } lcar_step_t;

  typedef struct packed {
    logic                       sck;
    logic                       busy;
    logic                       done;
    logic                       tout;
    logic                       tared;
    logic signed [RAW_W-1:0]    raw;
    logic signed [WEIGHT_W-1:0] weight;
  } lcar_res_t;

  function automatic logic signed [RAW_W-1:0] sext_sample(input logic [RAW_W-1:0] w);
    logic signed [RAW_W-1:0] r;
    for (int i = 0; i < RAW_W; i++) begin
      r[i] = (i < DATA_BITS) ? w[i] : w[DATA_BITS-1];
    end
    return r;
  endfunction

endpackage

[design/lcar_in_if.sv]
// Request channel carrying one converter tick: command and sampled data pin.
interface lcar_in_if import lcar_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic             dout;

  modport source(output valid, cmd, dout, input ready);
  modport sink(input valid, cmd, dout, output ready);
endinterface

[design/lcar_out_if.sv]
// Result channel carrying the pin level and read results of one tick.
interface lcar_out_if import lcar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       sck;
  logic                       busy_res;
  logic                       done_res;
  logic                       timed_out;
  logic signed [RAW_W-1:0]    raw;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       tare_valid;

  modport source(output valid, sck, busy_res, done_res, timed_out, raw, weight, tare_valid,
                 input ready);
  modport sink(input valid, sck, busy_res, done_res, timed_out, raw, weight, tare_valid,
               output ready);
endinterface

[design/lcar_cfg_if.sv]
// Register write channel of the load cell ADC reader.
interface lcar_cfg_if import lcar_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[design/lcar_ctrl.sv]
// Converter sequencer: wait for data ready, clock out the sample, tare accumulation.
module lcar_ctrl import lcar_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [CMD_W-1:0] cmd,
  input  logic             dout,
  input  lcar_cfg_t        cfg,
  output lcar_step_t       step
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WAIT = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_LOW  = 3'd3;
  localparam logic [2:0] PH_GAP  = 3'd4;

  logic [2:0]              phase_r, phase_nxt;
  logic [RAW_W-1:0]        shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0]    bits_r, bits_nxt;
  logic [1:0]              pulses_r, pulses_nxt;
  logic [CNT_W-1:0]        wait_r, wait_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [READS_W-1:0]      reads_r, reads_nxt;
  logic                    tared_r, tared_nxt;
  logic                    tmode_r, tmode_nxt;
  logic                    ttout_r, ttout_nxt;

  logic                    fin;
  logic                    rtout;
  logic signed [RAW_W-1:0] raw_f;
  logic signed [SUM_W-1:0] sum_add;

  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    pulses_nxt = pulses_r;
    wait_nxt   = wait_r;
    sum_nxt    = sum_r;
    reads_nxt  = reads_r;
    tared_nxt  = tared_r;
    tmode_nxt  = tmode_r;
    ttout_nxt  = ttout_r;
    fin        = 1'b0;
    rtout      = 1'b0;
    raw_f      = '0;
    sum_add    = '0;
    step       = '0;

    if (cfg.power_down) begin
      phase_nxt = PH_IDLE;
      reads_nxt = '0;
      sum_nxt   = '0;
      ttout_nxt = 1'b0;
      step.sck  = 1'b1;
    end else begin
      if (phase_r == PH_IDLE && (cmd == CMD_READ || cmd == CMD_TARE)) begin
        tmode_nxt = (cmd == CMD_TARE);
        sum_nxt   = '0;
        reads_nxt = '0;
        ttout_nxt = 1'b0;
        wait_nxt  = '0;
        phase_nxt = PH_WAIT;
      end

      unique case (phase_nxt)
        PH_WAIT: begin
          if (!dout) begin
            phase_nxt  = PH_HIGH;
            bits_nxt   = '0;
            pulses_nxt = '0;
            shift_nxt  = '0;
          end else if (wait_nxt >= cfg.timeout_ticks) begin
            fin   = 1'b1;
            rtout = 1'b1;
          end else begin
            wait_nxt = wait_nxt + 1'b1;
          end
        end
        PH_HIGH: begin
          step.sck  = 1'b1;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          if (bits_nxt < BIT_CNT_W'(DATA_BITS)) begin
            shift_nxt = {shift_nxt[RAW_W-2:0], dout};
            bits_nxt  = bits_nxt + 1'b1;
          end else begin
            pulses_nxt = pulses_nxt + 1'b1;
          end
          if (bits_nxt < BIT_CNT_W'(DATA_BITS) || pulses_nxt < cfg.gain_clks) begin
            phase_nxt = PH_HIGH;
          end else begin
            fin = 1'b1;
          end
        end
        PH_GAP: begin
          wait_nxt = wait_nxt + 1'b1;
          if (wait_nxt >= cfg.tare_gap_ticks) begin
            wait_nxt  = '0;
            phase_nxt = PH_WAIT;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      if (fin) begin
        raw_f = rtout ? '0 : sext_sample(shift_nxt);
        if (!tmode_nxt) begin
          phase_nxt = PH_IDLE;
          step.done = 1'b1;
          step.tout = rtout;
          step.raw  = raw_f;
        end else begin
          sum_add   = sum_nxt + SUM_W'(raw_f);
          reads_nxt = reads_nxt + 1'b1;
          if (rtout) begin
            ttout_nxt = 1'b1;
          end
          if (reads_nxt >= READS_W'(TARE_READS)) begin
            tared_nxt      = 1'b1;
            step.done      = 1'b1;
            step.tout      = ttout_nxt;
            step.raw       = raw_f;
            step.tare_done = 1'b1;
            step.sum       = sum_add;
            phase_nxt      = PH_IDLE;
            reads_nxt      = '0;
            sum_nxt        = '0;
            ttout_nxt      = 1'b0;
          end else begin
            sum_nxt   = sum_add;
            wait_nxt  = '0;
            phase_nxt = (cfg.tare_gap_ticks != '0) ? PH_GAP : PH_WAIT;
          end
        end
      end
    end

    step.valid = take;
    step.busy  = (phase_nxt != PH_IDLE);
    step.tared = tared_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      shift_r  <= '0;
      bits_r   <= '0;
      pulses_r <= '0;
      wait_r   <= '0;
      sum_r    <= '0;
      reads_r  <= '0;
      tared_r  <= 1'b0;
      tmode_r  <= 1'b0;
      ttout_r  <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      pulses_r <= pulses_nxt;
      wait_r   <= wait_nxt;
      sum_r    <= sum_nxt;
      reads_r  <= reads_nxt;
      tared_r  <= tared_nxt;
      tmode_r  <= tmode_nxt;
      ttout_r  <= ttout_nxt;
    end
  end

endmodule

[design/lcar_math.sv]
// Weight pipeline: tare average, offset subtraction, scaling and saturation.
module lcar_math import lcar_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  lcar_step_t         step,
  input  logic [SCALE_W-1:0] scale,
  output logic               res_valid,
  output lcar_res_t          res
);

  lcar_step_t a_r, b_r, c_r, d_r;
  logic       a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_valid_r;

  logic [SUM_W-1:0]         mag;
  logic [DIV_PROD_W-1:0]    b_prod_nxt, b_prod_r;
  logic                     b_neg_r;

  logic [RAW_W:0]           quot;
  logic signed [RAW_W:0]    off_new;
  logic signed [RAW_W-1:0]  off_use;
  logic signed [RAW_W-1:0]  offset_r;
  logic signed [RAW_W:0]    c_diff_nxt, c_diff_r;

  logic signed [PROD_W-1:0] d_prod_nxt, d_prod_r;

  logic [PROD_W-FRAC_SHIFT-1:0] shifted;
  logic [PROD_W-FRAC_SHIFT-WEIGHT_W:0] top_bits;
  logic signed [WEIGHT_W-1:0] weight_sat;
  lcar_res_t res_nxt, res_r;

  assign mag        = a_r.sum[SUM_W-1] ? SUM_W'(-a_r.sum) : SUM_W'(a_r.sum);
  assign b_prod_nxt = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_RECIP);

  assign quot       = b_prod_r[DIV_SHIFT +: RAW_W+1];
  assign off_new    = b_neg_r ? -$signed(quot) : $signed(quot);
  assign off_use    = b_r.tare_done ? off_new[RAW_W-1:0] : offset_r;
  assign c_diff_nxt = (RAW_W+1)'(b_r.raw) - (RAW_W+1)'(off_use);

  assign d_prod_nxt = PROD_W'(c_diff_r) * PROD_W'($signed({1'b0, scale}));

  assign shifted  = d_prod_r[PROD_W-1:FRAC_SHIFT];
  assign top_bits = shifted[PROD_W-FRAC_SHIFT-1:WEIGHT_W-1];

  always_comb begin
    if (&top_bits || ~|top_bits) begin
      weight_sat = shifted[WEIGHT_W-1:0];
    end else if (top_bits[PROD_W-FRAC_SHIFT-WEIGHT_W]) begin
      weight_sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      weight_sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
    res_nxt.sck    = d_r.sck;
    res_nxt.busy   = d_r.busy;
    res_nxt.done   = d_r.done;
    res_nxt.tout   = d_r.tout;
    res_nxt.tared  = d_r.tared;
    res_nxt.raw    = d_r.raw;
    res_nxt.weight = d_r.done ? weight_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      offset_r  <= '0;
    end else if (en) begin
      a_valid_r <= step.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
      if (b_valid_r && b_r.tare_done) begin
        offset_r <= off_new[RAW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= step;
      b_r      <= a_r;
      b_prod_r <= b_prod_nxt;
      b_neg_r  <= a_r.sum[SUM_W-1];
      c_r      <= b_r;
      c_diff_r <= c_diff_nxt;
      d_r      <= c_r;
      d_prod_r <= d_prod_nxt;
      res_r    <= res_nxt;
    end
  end

  assign res_valid = e_valid_r;
  assign res       = res_r;

endmodule

[design/load_cell_adc_reader.sv]
// Top level of the load cell ADC reader: registers, sequencer and weight pipeline.
//
// Each request is one half-bit tick of the converter's two-wire link. The block
// takes one tick every clock cycle and returns exactly one result per tick, in
// order; each result passes through five register stages: the input stage
// and the weight pipeline (tare averaging by reciprocal multiply, offset
// subtraction, the 25 by 33 bit scale multiply, and saturation). When the
// result side stalls, the whole pipeline holds and the request side stalls
// with it. Register writes are accepted in every cycle and must only be
// issued while idle.
module load_cell_adc_reader import lcar_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  lcar_in_if.sink     in_if,
  lcar_out_if.source  out_if,
  lcar_cfg_if.sink    cfg_if
);

  lcar_cfg_t  cfg_r, cfg_nxt;
  lcar_step_t step;
  lcar_res_t  res;
  logic       res_valid;
  logic       en;
  logic       take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_GAIN_CLKS:   cfg_nxt.gain_clks      = cfg_if.data[1:0];
        REG_TIMEOUT:     cfg_nxt.timeout_ticks  = cfg_if.data[CNT_W-1:0];
        REG_TARE_GAP:    cfg_nxt.tare_gap_ticks = cfg_if.data[CNT_W-1:0];
        REG_SCALE_RECIP: cfg_nxt.scale_recip    = cfg_if.data[SCALE_W-1:0];
        REG_POWER_DOWN:  cfg_nxt.power_down     = cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_clks      <= 2'd1;
      cfg_r.timeout_ticks  <= CNT_W'(1000000);
      cfg_r.tare_gap_ticks <= CNT_W'(100000);
      cfg_r.scale_recip    <= SCALE_W'(16777216);
      cfg_r.power_down     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_if.ready = 1'b1;

  assign en          = !res_valid || out_if.ready;
  assign in_if.ready = en;
  assign take        = in_if.valid && en;

  lcar_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .cmd   (in_if.cmd),
    .dout  (in_if.dout),
    .cfg   (cfg_r),
    .step  (step)
  );

  lcar_math u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .step      (step),
    .scale     (cfg_r.scale_recip),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_if.valid      = res_valid;
  assign out_if.sck        = res.sck;
  assign out_if.busy_res   = res.busy;
  assign out_if.done_res   = res.done;
  assign out_if.timed_out  = res.tout;
  assign out_if.raw        = res.raw;
  assign out_if.weight     = res.weight;
  assign out_if.tare_valid = res.tared;

  // A finished operation always leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.done_res |-> !out_if.busy_res)
    else $error("done reported while still busy");

  // A timeout only comes with done.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.timed_out |-> out_if.done_res)
    else $error("timeout reported without done");

  // Ticks without done carry no sample or weight.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.done_res |-> out_if.raw == '0 && out_if.weight == '0)
    else $error("sample fields set on a tick without done");

  // Power down drives the clock pin high and drops any operation.
  assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && cfg_r.power_down |-> step.sck && !step.busy && !step.done)
    else $error("power down not honored by the sequencer");

endmodule
